[src/iale_pkg.sv]
`timescale 1ns / 1ps

package iale_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int REQ_W  = 3;
    localparam int ST_W   = 3;

    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MINMAX = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_INVALID  = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] insert_value;
        logic signed [DATA_W-1:0] search_key;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic [POS_W-1:0]         position_out;
        logic signed [DATA_W-1:0] data_out;
        logic signed [DATA_W-1:0] max_out;
        logic                     last;
    } rsp_t;

endpackage

[src/iale_ram.sv]
`timescale 1ns / 1ps

module iale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/indexed_array_list_engine_unit.sv]
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit elements held in one RAM.
// Requests arrive on req/req_valid/req_ready, results leave on
// rsp/rsp_valid/rsp_ready; both are valid/ready channels, one item per
// accepted handshake. One request is worked at a time; req_ready is high
// whenever the engine is idle, even while a finished result still waits.
// While a request is worked req_ready stays low; p is the position, n the element count:
//   insert        shifts p..n-1 up one slot (one RAM read and one write per shifted element)
//   delete        shifts p+1..n-1 down one slot
//   search/minmax one RAM read per element
//   read out      one RAM read per element
//   refused or empty-list requests: no RAM access
// The next request can be accepted in the idle cycle that follows.
// The single read port of the element RAM allows one element read at a time. A search
// emits one item per match (one not-found item if none), a read out one per element; the
// last item of every request has last set. A stalled receiver holds the result register and
// the element walk waits with it. Reset clears the count and the control
// state; the RAM is not cleared and needs no pass after reset.
module indexed_array_list_engine_unit
    import iale_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_SCAN,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [REQ_W-1:0]  op_reg, op_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [AW-1:0]     ra_reg, ra_next;
    logic [AW-1:0]     di_reg, di_next;
    logic              dv_reg, dv_next;
    logic [DATA_W-1:0] mn_reg, mn_next;
    logic [DATA_W-1:0] mx_reg, mx_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_pos_reg, pend_pos_next;
    logic [ST_W-1:0]   fin_st_reg, fin_st_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              out_free;
    logic              req_fire;
    logic [EW-1:0]     n_ext;
    logic [EW-1:0]     p_ext;
    logic              match;
    logic              need_out;
    logic              stall;

    iale_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign n_ext = EW'(cnt_reg);
    assign p_ext = EW'(req.position);
    assign match = (ram_rdata == key_reg);

    always_comb
    begin
        need_out = 1'b0;
        if (op_reg == REQ_READ)
        begin
            need_out = 1'b1;
        end
        else if (op_reg == REQ_SEARCH)
        begin
            need_out = match && pend_reg;
        end
        stall = (state_reg == S_SCAN) && dv_reg && need_out && !out_free;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        key_next       = key_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        ra_next        = ra_reg;
        di_next        = di_reg;
        dv_next        = dv_reg;
        mn_next        = mn_reg;
        mx_next        = mx_reg;
        pend_next      = pend_reg;
        pend_pos_next  = pend_pos_reg;
        fin_st_next    = fin_st_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = di_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = ra_reg;

        case (state_reg)
            S_IDLE:
            begin
                dv_next = 1'b0;
                if (req_fire)
                begin
                    op_next   = req.req_type;
                    pos_next  = req.position;
                    val_next  = req.insert_value;
                    key_next  = req.search_key;
                    pend_next = 1'b0;
                    case (req.req_type)
                        REQ_INSERT:
                        begin
                            if (n_ext >= EW'(DEPTH))
                            begin
                                fin_st_next = ST_FULL;
                                state_next  = S_FIN;
                            end
                            else if (p_ext > n_ext)
                            begin
                                fin_st_next = ST_INVALID;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                rem_next   = CW'(n_ext - p_ext);
                                ra_next    = AW'(cnt_reg - CW'(1));
                                state_next = S_INS;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin_st_next = ST_EMPTY;
                                state_next  = S_FIN;
                            end
                            else if (p_ext >= n_ext)
                            begin
                                fin_st_next = ST_INVALID;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                rem_next   = CW'(n_ext - p_ext - EW'(1));
                                ra_next    = AW'(p_ext + EW'(1));
                                state_next = S_DEL;
                            end
                        end
                        REQ_SEARCH, REQ_MINMAX, REQ_READ:
                        begin
                            if (req.req_type == REQ_SEARCH)
                            begin
                                fin_st_next = ST_NOTFOUND;
                            end
                            else if (cnt_reg == '0)
                            begin
                                fin_st_next = ST_EMPTY;
                            end
                            else
                            begin
                                fin_st_next = ST_OK;
                            end
                            if (cnt_reg == '0)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                rem_next   = cnt_reg;
                                ra_next    = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                // move each element up one slot, highest first
                if (dv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = di_reg + AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (rem_reg != '0)
                begin
                    ram_re   = 1'b1;
                    ram_raddr = ra_reg;
                    ra_next  = ra_reg - AW'(1);
                    rem_next = rem_reg - CW'(1);
                    di_next  = ra_reg;
                    dv_next  = 1'b1;
                end
                else
                begin
                    dv_next = 1'b0;
                    if (!dv_reg)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = pos_reg[AW-1:0];
                        ram_wdata   = val_reg;
                        cnt_next    = cnt_reg + CW'(1);
                        fin_st_next = ST_OK;
                        state_next  = S_FIN;
                    end
                end
            end

            S_DEL:
            begin
                // move each later element down one slot, lowest first
                if (dv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = di_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (rem_reg != '0)
                begin
                    ram_re   = 1'b1;
                    ram_raddr = ra_reg;
                    ra_next  = ra_reg + AW'(1);
                    rem_next = rem_reg - CW'(1);
                    di_next  = ra_reg;
                    dv_next  = 1'b1;
                end
                else
                begin
                    dv_next = 1'b0;
                    if (!dv_reg)
                    begin
                        cnt_next    = cnt_reg - CW'(1);
                        fin_st_next = ST_OK;
                        state_next  = S_FIN;
                    end
                end
            end

            S_SCAN:
            begin
                if (!stall)
                begin
                    if (rem_reg != '0)
                    begin
                        ram_re   = 1'b1;
                        ram_raddr = ra_reg;
                        ra_next  = ra_reg + AW'(1);
                        rem_next = rem_reg - CW'(1);
                        di_next  = ra_reg;
                        dv_next  = 1'b1;
                    end
                    else
                    begin
                        dv_next = 1'b0;
                    end

                    if (dv_reg)
                    begin
                        case (op_reg)
                            REQ_MINMAX:
                            begin
                                if (di_reg == '0)
                                begin
                                    mn_next = ram_rdata;
                                    mx_next = ram_rdata;
                                end
                                else
                                begin
                                    if ($signed(ram_rdata) < $signed(mn_reg))
                                    begin
                                        mn_next = ram_rdata;
                                    end
                                    if ($signed(ram_rdata) > $signed(mx_reg))
                                    begin
                                        mx_next = ram_rdata;
                                    end
                                end
                            end
                            REQ_SEARCH:
                            begin
                                if (match)
                                begin
                                    // hold the newest hit back until it is known to be last
                                    if (pend_reg)
                                    begin
                                        out_valid_next        = 1'b1;
                                        out_next.status       = ST_OK;
                                        out_next.position_out = POS_W'(pend_pos_reg);
                                        out_next.data_out     = '0;
                                        out_next.max_out      = '0;
                                        out_next.last         = 1'b0;
                                    end
                                    pend_next     = 1'b1;
                                    pend_pos_next = di_reg;
                                end
                            end
                            default:
                            begin
                                out_valid_next        = 1'b1;
                                out_next.status       = ST_OK;
                                out_next.position_out = POS_W'(di_reg);
                                out_next.data_out     = ram_rdata;
                                out_next.max_out      = '0;
                                out_next.last         = (CW'(di_reg) == cnt_reg - CW'(1));
                            end
                        endcase
                    end

                    if (rem_reg == '0 && !dv_reg)
                    begin
                        state_next = (op_reg == REQ_READ) ? S_IDLE : S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = fin_st_reg;
                    out_next.position_out = '0;
                    out_next.data_out     = '0;
                    out_next.max_out      = '0;
                    out_next.last         = 1'b1;
                    if (op_reg == REQ_SEARCH && pend_reg)
                    begin
                        out_next.status       = ST_OK;
                        out_next.position_out = POS_W'(pend_pos_reg);
                    end
                    else if (op_reg == REQ_MINMAX && fin_st_reg == ST_OK)
                    begin
                        out_next.data_out = mn_reg;
                        out_next.max_out  = mx_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= REQ_INSERT;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            dv_reg        <= 1'b0;
            pend_reg      <= 1'b0;
            fin_st_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            dv_reg        <= dv_next;
            pend_reg      <= pend_next;
            fin_st_reg    <= fin_st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        key_reg      <= key_next;
        ra_reg       <= ra_next;
        di_reg       <= di_next;
        mn_reg       <= mn_next;
        mx_reg       <= mx_next;
        pend_pos_reg <= pend_pos_next;
        out_reg      <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !dv_reg)
        else $error("read data in flight while idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(cnt_reg) <= EW'(DEPTH))
        else $error("element count beyond depth");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            ($past(state_reg) == S_INS || $past(state_reg) == S_DEL))
        else $error("element count changed outside insert or delete");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (state_reg != S_IDLE || $stable(rsp)))
        else $error("pending result overwritten");
`endif

endmodule
